// ===== rtl/qlte_pkg.sv =====
package qlte_pkg;

    // Operation carried by every input item.
    typedef enum logic [1:0] {
        OP_CHOOSE = 2'd0,
        OP_UPDATE = 2'd1,
        OP_WRITE  = 2'd2,
        OP_READ   = 2'd3
    } qlte_op_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEARN_RATE     = 2'd0;
    localparam logic [1:0] CFG_DISCOUNT       = 2'd1;
    localparam logic [1:0] CFG_EXPLORE_CHANCE = 2'd2;

    // Configuration reset values (unsigned Q0.16).
    localparam logic [15:0] LEARN_RATE_RST     = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST       = 16'd58982;
    localparam logic [15:0] EXPLORE_CHANCE_RST = 16'd6554;

    typedef struct packed {
        qlte_op_t           opcode;
        logic [3:0]         state_index;
        logic [1:0]         action;
        logic signed [15:0] reward;
        logic [3:0]         next_state;
        logic [15:0]        explore_draw;
        logic [1:0]         random_action;
        logic signed [15:0] write_value;
    } qlte_in_t;

    typedef struct packed {
        logic [1:0]         chosen_action;
        logic signed [15:0] entry_value;
        logic               explored;
    } qlte_out_t;

    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] discount;
        logic [15:0] explore_chance;
    } qlte_cfg_t;

    // Handshake between the top level and the sequencer.
    typedef struct packed {
        logic start;
        logic ack;
    } qlte_eng_ctrl_t;

    typedef struct packed {
        logic ready;
        logic done;
    } qlte_eng_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FETCH,
        ST_FETCHED,
        ST_QREAD,
        ST_TD,
        ST_SCALE,
        ST_APPLY,
        ST_WRITE,
        ST_DONE
    } qlte_state_t;

endpackage

// ===== rtl/q_learning_table_engine_core.sv =====
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+------------------------------------------
// s_*      | in  | s_valid / s_ready     | qlte_in_t: opcode, states, action, reward
// m_*      | out | m_valid / m_ready     | qlte_out_t: chosen_action, value, explored
// cfg_*    | in  | cfg_wr_en (no wait)   | cfg_index, cfg_wr_data (alpha/gamma/eps)
//
// One item is worked on at a time: a new item is not accepted until the last
// result has left the sequencer. A greedy choose and an update walk a row
// through the single table read port one entry per cycle, and an update then
// does two dependent multiplies. After reset a clearing pass writes zero over
// all table words, one per cycle, and s_ready stays low until it ends. The
// result sits in an output register, so a stalled m_ready does not block the
// next s_valid transfer; only a second finished result waits in the sequencer
// until the register frees up.
module q_learning_table_engine_core
    import qlte_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_ACTIONS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  qlte_in_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output qlte_out_t   m_payload
);

    localparam int SW     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int AW     = $clog2(NUM_ACTIONS);
    localparam int ADDR_W = SW + AW;

    // Configuration registers. The user must issue writes only while the block is idle; the block does not enforce it.
    qlte_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LEARN_RATE:     cfg_next.learn_rate     = cfg_wr_data;
                CFG_DISCOUNT:       cfg_next.discount       = cfg_wr_data;
                CFG_EXPLORE_CHANCE: cfg_next.explore_chance = cfg_wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.learn_rate     <= LEARN_RATE_RST;
            cfg_reg.discount       <= DISCOUNT_RST;
            cfg_reg.explore_chance <= EXPLORE_CHANCE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer and table.
    qlte_eng_ctrl_t     eng_ctrl;
    qlte_eng_stat_t     eng_stat;
    qlte_out_t          eng_result;
    logic               mem_rd_en, mem_wr_en;
    logic [ADDR_W-1:0]  mem_rd_addr, mem_wr_addr;
    logic signed [15:0] mem_rd_data, mem_wr_data;

    // Output register: holds one finished result until its transfer.
    logic      m_valid_reg, m_valid_next;
    qlte_out_t m_payload_reg, m_payload_next;

    // The result register is free when empty or being drained this cycle.
    logic out_free, eng_take;

    assign out_free = !m_valid_reg || m_ready;
    assign eng_take = eng_stat.done && out_free;

    assign eng_ctrl.start = s_valid;
    assign eng_ctrl.ack   = eng_take;
    assign s_ready        = eng_stat.ready;

    qlte_engine #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .ctrl        (eng_ctrl),
        .item_in     (s_payload),
        .stat        (eng_stat),
        .result      (eng_result),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    qlte_table #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (eng_take) begin
            m_valid_next   = 1'b1;
            m_payload_next = eng_result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // An accepted item keeps the sequencer busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again right after a transfer");

    // A finished result handed to a free output register must show up.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_take |=> m_valid)
        else $error("finished result not presented on the output");

    // A drained output register empties unless a new result is loaded.
    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !eng_take) |=> !m_valid)
        else $error("result repeated after its transfer");

endmodule

// ===== rtl/qlte_table.sv =====
module qlte_table #(
    parameter int ADDR_W = 6
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic signed [15:0]       rd_data,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [15:0]       wr_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic signed [15:0] mem_q [DEPTH];
    logic signed [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/qlte_engine.sv =====
module qlte_engine
    import qlte_pkg::*;
#(
    parameter int  NUM_STATES  = 16,
    parameter int  NUM_ACTIONS = 4,
    localparam int SW          = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1,
    localparam int AW          = $clog2(NUM_ACTIONS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qlte_cfg_t             cfg,
    input  qlte_eng_ctrl_t        ctrl,
    input  qlte_in_t              item_in,
    output qlte_eng_stat_t        stat,
    output qlte_out_t             result,
    output logic                  mem_rd_en,
    output logic [SW+AW-1:0]      mem_rd_addr,
    input  logic signed [15:0]    mem_rd_data,
    output logic                  mem_wr_en,
    output logic [SW+AW-1:0]      mem_wr_addr,
    output logic signed [15:0]    mem_wr_data
);

    localparam int ADDR_W = SW + AW;
    localparam int CW     = $clog2(NUM_ACTIONS + 1);

    // Row-major layout with a power-of-two row stride: {state, action}.
    function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] s,
                                                  input logic [AW-1:0] a);
        return {SW'(s), a};
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
        logic signed [15:0] y;
        if (x > 20'sd32767) begin
            y = 16'sh7fff;
        end else if (x < -20'sd32768) begin
            y = 16'sh8000;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

    qlte_state_t        state_reg, state_next;
    qlte_in_t           item_reg, item_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [AW-1:0]      rd_act_reg, rd_act_next;
    logic signed [15:0] best_reg, best_next;
    logic [AW-1:0]      best_act_reg, best_act_next;
    logic [AW-1:0]      chosen_reg, chosen_next;
    logic               explored_reg, explored_next;
    logic signed [15:0] q_reg, q_next;
    logic signed [32:0] prod1_reg, prod1_next;
    logic signed [17:0] td_reg, td_next;
    logic signed [34:0] prod2_reg, prod2_next;
    qlte_out_t          res_reg, res_next;

    logic               st_ok, act_ok, nst_ok, entry_ok, scan_ok, fetch_ok;
    logic [3:0]         scan_state;
    logic signed [15:0] scan_d, fetch_d, best_cur;
    logic [AW-1:0]      best_act_cur, ract_mod;
    logic               scan_take;
    logic signed [16:0] alpha_s, gamma_s;
    logic signed [32:0] mul1;
    logic signed [34:0] mul2;
    logic signed [17:0] td_sum;
    logic signed [19:0] upd_sum;
    logic signed [15:0] upd_sat;

    assign st_ok    = int'(item_reg.state_index) < NUM_STATES;
    assign nst_ok   = int'(item_reg.next_state) < NUM_STATES;
    assign act_ok   = int'(item_reg.action) < NUM_ACTIONS;
    assign entry_ok = st_ok && act_ok;
    assign scan_ok  = (item_reg.opcode == OP_UPDATE) ? nst_ok : st_ok;
    assign fetch_ok = explored_reg ? st_ok : entry_ok;
    assign scan_state = (item_reg.opcode == OP_UPDATE) ? item_reg.next_state
                                                       : item_reg.state_index;

    // Entries outside the table read as zero.
    assign scan_d  = scan_ok ? mem_rd_data : 16'sd0;
    assign fetch_d = fetch_ok ? mem_rd_data : 16'sd0;

    // Running maximum; strict compare keeps ties on the lowest action.
    assign scan_take    = rd_pend_reg && ((rd_act_reg == '0) || (scan_d > best_reg));
    assign best_cur     = scan_take ? scan_d : best_reg;
    assign best_act_cur = scan_take ? rd_act_reg : best_act_reg;

    // The random action is below 2*NUM_ACTIONS, so one subtract reduces it.
    assign ract_mod = (int'(item_reg.random_action) >= NUM_ACTIONS)
                    ? AW'(int'(item_reg.random_action) - NUM_ACTIONS)
                    : AW'(item_reg.random_action);

    assign alpha_s = $signed({1'b0, cfg.learn_rate});
    assign gamma_s = $signed({1'b0, cfg.discount});
    assign mul1    = gamma_s * best_reg;
    assign td_sum  = item_reg.reward + $signed(prod1_reg[32:16]) - q_reg;
    assign mul2    = alpha_s * td_reg;
    assign upd_sum = q_reg + $signed(prod2_reg[34:16]);
    assign upd_sat = sat16(upd_sum);

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        clr_next      = clr_reg;
        rd_pend_next  = rd_pend_reg;
        rd_act_next   = rd_act_reg;
        best_next     = best_reg;
        best_act_next = best_act_reg;
        chosen_next   = chosen_reg;
        explored_next = explored_reg;
        q_next        = q_reg;
        prod1_next    = prod1_reg;
        td_next       = td_reg;
        prod2_next    = prod2_reg;
        res_next      = res_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = '0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = '0;
        mem_wr_data   = 16'sd0;

        case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (ctrl.start) begin
                    item_next  = item_in;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                idx_next      = '0;
                rd_pend_next  = 1'b0;
                explored_next = 1'b0;
                chosen_next   = AW'(item_reg.action);
                case (item_reg.opcode)
                    OP_CHOOSE: begin
                        if (item_reg.explore_draw < cfg.explore_chance) begin
                            explored_next = 1'b1;
                            chosen_next   = ract_mod;
                            state_next    = ST_FETCH;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_UPDATE: state_next = ST_SCAN;
                    OP_WRITE:  state_next = ST_WRITE;
                    OP_READ:   state_next = ST_FETCH;
                    default:   state_next = ST_FETCH;
                endcase
            end
            ST_SCAN: begin
                best_next     = best_cur;
                best_act_next = best_act_cur;
                if (idx_reg != CW'(NUM_ACTIONS)) begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = addr_of(scan_state, idx_reg[AW-1:0]);
                    rd_pend_next = 1'b1;
                    rd_act_next  = idx_reg[AW-1:0];
                    idx_next     = idx_reg + 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (item_reg.opcode == OP_UPDATE) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = addr_of(item_reg.state_index, AW'(item_reg.action));
                        state_next  = ST_QREAD;
                    end else begin
                        res_next.chosen_action = 2'(best_act_cur);
                        res_next.entry_value   = best_cur;
                        res_next.explored      = 1'b0;
                        state_next             = ST_DONE;
                    end
                end
            end
            ST_FETCH: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_of(item_reg.state_index,
                                      explored_reg ? chosen_reg : AW'(item_reg.action));
                state_next  = ST_FETCHED;
            end
            ST_FETCHED: begin
                res_next.chosen_action = explored_reg ? 2'(chosen_reg) : item_reg.action;
                res_next.entry_value   = fetch_d;
                res_next.explored      = explored_reg;
                state_next             = ST_DONE;
            end
            ST_QREAD: begin
                q_next     = fetch_d;
                prod1_next = mul1;
                state_next = ST_TD;
            end
            ST_TD: begin
                td_next    = td_sum;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                prod2_next = mul2;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                mem_wr_en              = entry_ok;
                mem_wr_addr            = addr_of(item_reg.state_index, AW'(item_reg.action));
                mem_wr_data            = upd_sat;
                res_next.chosen_action = item_reg.action;
                res_next.entry_value   = entry_ok ? upd_sat : 16'sd0;
                res_next.explored      = 1'b0;
                state_next             = ST_DONE;
            end
            ST_WRITE: begin
                mem_wr_en              = entry_ok;
                mem_wr_addr            = addr_of(item_reg.state_index, AW'(item_reg.action));
                mem_wr_data            = item_reg.write_value;
                res_next.chosen_action = item_reg.action;
                res_next.entry_value   = entry_ok ? item_reg.write_value : 16'sd0;
                res_next.explored      = 1'b0;
                state_next             = ST_DONE;
            end
            ST_DONE: begin
                if (ctrl.ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        rd_act_reg   <= rd_act_next;
        best_reg     <= best_next;
        best_act_reg <= best_act_next;
        chosen_reg   <= chosen_next;
        explored_reg <= explored_next;
        q_reg        <= q_next;
        prod1_reg    <= prod1_next;
        td_reg       <= td_next;
        prod2_reg    <= prod2_next;
        res_reg      <= res_next;
    end

    assign stat.ready = (state_reg == ST_IDLE);
    assign stat.done  = (state_reg == ST_DONE);
    assign result     = res_reg;

    // The single-port schedule never reads and writes the table in one cycle.
    a_no_rd_wr_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> !mem_rd_en)
        else $error("table read and write in the same cycle");

    // When the last row entry is consumed, its read must have been issued.
    a_scan_tail_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && idx_reg == CW'(NUM_ACTIONS)) |-> rd_pend_reg)
        else $error("row scan finished without the last read in flight");

    // Only a choose operation may report exploration.
    a_explored_choose: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_reg.explored) |-> (item_reg.opcode == OP_CHOOSE))
        else $error("explored flag set for a non-choose operation");

endmodule
